// ----- rtl/core/mm_pkg.sv -----
// Shared types, constants and helpers of the matrix multiply block.
// Used by mm_mac and matrix_multiply through scoped names; depends on nothing.

package mm_pkg;

   localparam int MAX_DIM = 8;                  // largest row/column count
   localparam int IDX_W   = $clog2(MAX_DIM);    // row or column index
   localparam int DIM_W   = IDX_W + 1;          // a count 1..MAX_DIM
   localparam int ADDR_W  = 2 * IDX_W;          // store entry, row-major
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int CSR_W   = 4;                  // widest register
   localparam int VAL_W   = 32;                 // Q16.16 element
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 2 * VAL_W;          // Q32.32 product
   localparam int ACC_W   = PROD_W + IDX_W;     // exact sum of MAX_DIM products

   typedef enum logic [1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_COLS_A = 2'd1,
      CSR_ROWS_B = 2'd2,
      CSR_COLS_B = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_ERROR
   } state_type;

   // token that travels with one pair of operands into the MAC
   typedef struct packed {
      logic valid;
      logic first;
   } mac_tok_type;

   // clamp a register value to the range 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CSR_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/mm_mac.sv -----
// Multiply-accumulate datapath: registered 32x32 product, exact accumulator,
// floor to Q16.16 and saturation. Depends on mm_pkg.

module mm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mm_pkg::mac_tok_type                 tok,
   input  logic signed [mm_pkg::VAL_W-1:0]     opnd_a,
   input  logic signed [mm_pkg::VAL_W-1:0]     opnd_b,
   output logic                                busy,
   output logic signed [mm_pkg::VAL_W-1:0]     result
);

   localparam int TOP_W = mm_pkg::ACC_W - (mm_pkg::FRAC_W + mm_pkg::VAL_W - 1);

   logic signed [mm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                             mul_vld_ff;
   logic                             mul_first_ff;
   logic signed [mm_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic        [TOP_W-1:0]          acc_top;

   assign prod_in = mm_pkg::PROD_W'(opnd_a) * mm_pkg::PROD_W'(opnd_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff   <= 1'b0;
         mul_first_ff <= 1'b0;
      end else begin
         mul_vld_ff   <= tok.valid;
         mul_first_ff <= tok.first;
      end
   end

   always_ff @(posedge clock) begin
      if (tok.valid) begin
         prod_ff <= prod_in;
      end
      if (mul_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // restart the sum on the first term of an element
   always_comb begin
      if (mul_first_ff) begin
         acc_in = mm_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + mm_pkg::ACC_W'(prod_ff);
      end
   end

   // floor by dropping the fraction, clamp when the upper bits disagree
   assign acc_top = acc_ff[mm_pkg::ACC_W-1 -: TOP_W];

   always_comb begin
      if (acc_top == '0 || acc_top == '1) begin
         result = acc_ff[mm_pkg::FRAC_W +: mm_pkg::VAL_W];
      end else if (acc_top[TOP_W-1]) begin
         result = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
      end
   end

   assign busy = mul_vld_ff;

endmodule

// ----- rtl/core/matrix_multiply.sv -----
// Top level of the matrix multiply block: element stores, sequencer, result register.
// Depends on mm_pkg and mm_mac.
//
// Usage:
//  - req channel (valid/stall): each transfer is one item. op OP_WRITE_A or
//    OP_WRITE_B writes one element of A or B; writes outside the configured
//    size are dropped. Loads stream at one per cycle while the sequencer is idle.
//  - op OP_COMPUTE walks the product row-major. Each product element takes
//    cols_a reads of the two stores (one port each, one term per cycle
//    through the shared multiplier), then passes the read register, multiply
//    and accumulate stages. req_stall stays high while a run is in progress.
//  - A size mismatch (cols_a != rows_b) gives one zero result with
//    size_error and last set, loaded via ST_ERROR once the output register is free.
//  - rsp channel (valid/stall): results come from an output register. When
//    the receiver stalls, the walk holds before loading the next element;
//    loads are still taken while the final result of a run waits.
//  - csr port: write-only, taken in any cycle; write it only while idle.
//  - reset (synchronous): registers return to 1 and both stores read as zero
//    at once through per-entry valid flags; no clearing pass is needed.

module matrix_multiply (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_wen,
   input  logic [1:0]                       csr_index,
   input  logic [mm_pkg::CSR_W-1:0]         csr_wdata,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [2:0]                       req_row_index,
   input  logic [2:0]                       req_col_index,
   input  logic signed [31:0]               req_elem_value,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_out_row,
   output logic [2:0]                       rsp_out_col,
   output logic signed [31:0]               rsp_out_value,
   output logic                             rsp_last,
   output logic                             rsp_size_error
);

   // clamped sizes
   logic [mm_pkg::DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;

   // element stores and their valid flags
   logic signed [mm_pkg::VAL_W-1:0] store_a_mem [mm_pkg::DEPTH];
   logic signed [mm_pkg::VAL_W-1:0] store_b_mem [mm_pkg::DEPTH];
   logic [mm_pkg::DEPTH-1:0]        vld_a_ff, vld_b_ff;

   logic signed [mm_pkg::VAL_W-1:0] a_rd_ff, b_rd_ff;
   logic                            a_hit_ff, b_hit_ff;
   mm_pkg::mac_tok_type             rd_tok_ff, rd_tok_in;

   // sequencer
   mm_pkg::state_type        state_ff, state_in;
   logic [mm_pkg::IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mm_pkg::IDX_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [mm_pkg::VAL_W-1:0] rsp_value_ff;
   logic                            rsp_last_ff, rsp_err_ff;

   logic req_accept, is_compute, wr_a, wr_b, size_ok;
   logic k_last, elem_last, pipe_empty, out_free;
   logic rd_en, load_elem, load_err, start_run;
   logic mac_busy;
   logic signed [mm_pkg::VAL_W-1:0] mac_result;
   logic signed [mm_pkg::VAL_W-1:0] opnd_a, opnd_b;
   logic [mm_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= mm_pkg::DIM_W'(1);
         cols_a_ff <= mm_pkg::DIM_W'(1);
         rows_b_ff <= mm_pkg::DIM_W'(1);
         cols_b_ff <= mm_pkg::DIM_W'(1);
      end else if (csr_wen) begin
         unique case (mm_pkg::csr_index_type'(csr_index))
            mm_pkg::CSR_ROWS_A: rows_a_ff <= mm_pkg::eff_dim(csr_wdata);
            mm_pkg::CSR_COLS_A: cols_a_ff <= mm_pkg::eff_dim(csr_wdata);
            mm_pkg::CSR_ROWS_B: rows_b_ff <= mm_pkg::eff_dim(csr_wdata);
            mm_pkg::CSR_COLS_B: cols_b_ff <= mm_pkg::eff_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ request decode
   assign req_accept = req_valid && !req_stall;
   assign wr_addr    = {req_row_index, req_col_index};
   assign size_ok    = (cols_a_ff == rows_b_ff);

   always_comb begin
      wr_a       = 1'b0;
      wr_b       = 1'b0;
      is_compute = 1'b0;
      case (req_op)
         mm_pkg::OP_WRITE_A:
            wr_a = req_accept && ({1'b0, req_row_index} < rows_a_ff)
                   && ({1'b0, req_col_index} < cols_a_ff);
         mm_pkg::OP_WRITE_B:
            wr_b = req_accept && ({1'b0, req_row_index} < rows_b_ff)
                   && ({1'b0, req_col_index} < cols_b_ff);
         mm_pkg::OP_COMPUTE:
            is_compute = req_accept;
         default: ;   // unused code: drop
      endcase
   end

   // ---------------------------------------------------------------- stores
   assign rd_addr_a = {i_ff, k_ff};
   assign rd_addr_b = {k_ff, j_ff};

   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a_mem[wr_addr] <= req_elem_value;
      end
      if (wr_b) begin
         store_b_mem[wr_addr] <= req_elem_value;
      end
      if (rd_en) begin
         a_rd_ff  <= store_a_mem[rd_addr_a];
         b_rd_ff  <= store_b_mem[rd_addr_b];
         a_hit_ff <= vld_a_ff[rd_addr_a];
         b_hit_ff <= vld_b_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= '0;
         vld_b_ff <= '0;
      end else begin
         if (wr_a) vld_a_ff[wr_addr] <= 1'b1;
         if (wr_b) vld_b_ff[wr_addr] <= 1'b1;
      end
   end

   // an entry never written reads as zero
   assign opnd_a = a_hit_ff ? a_rd_ff : '0;
   assign opnd_b = b_hit_ff ? b_rd_ff : '0;

   always_comb begin
      rd_tok_in.valid = rd_en;
      rd_tok_in.first = rd_en && (k_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tok_ff <= '0;
      end else begin
         rd_tok_ff <= rd_tok_in;
      end
   end

   mm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tok    (rd_tok_ff),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .busy   (mac_busy),
      .result (mac_result)
   );

   // ------------------------------------------------------------- sequencer
   assign k_last     = ({1'b0, k_ff} == cols_a_ff - 1'b1);
   assign elem_last  = ({1'b0, i_ff} == rows_a_ff - 1'b1)
                       && ({1'b0, j_ff} == cols_b_ff - 1'b1);
   assign pipe_empty = !rd_tok_ff.valid && !mac_busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (is_compute) begin
               state_in = size_ok ? mm_pkg::ST_READ : mm_pkg::ST_ERROR;
            end
         end
         mm_pkg::ST_READ: begin
            if (k_last) state_in = mm_pkg::ST_DRAIN;
         end
         mm_pkg::ST_DRAIN: begin
            if (pipe_empty && out_free) begin
               state_in = elem_last ? mm_pkg::ST_IDLE : mm_pkg::ST_READ;
            end
         end
         mm_pkg::ST_ERROR: begin
            if (out_free) state_in = mm_pkg::ST_IDLE;
         end
         default: state_in = mm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      load_elem = 1'b0;
      load_err  = 1'b0;
      start_run = 1'b0;
      unique case (state_ff)
         mm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            start_run = is_compute;
         end
         mm_pkg::ST_READ:  rd_en     = 1'b1;
         mm_pkg::ST_DRAIN: load_elem = pipe_empty && out_free;
         mm_pkg::ST_ERROR: load_err  = out_free;
         default: ;
      endcase
   end

   // indices: k steps per term, j and i step per element
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (start_run) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (rd_en) begin
         k_in = k_last ? '0 : k_ff + 1'b1;
      end else if (load_elem) begin
         if ({1'b0, j_ff} == cols_b_ff - 1'b1) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // --------------------------------------------------------- result register
   always_comb begin
      if (load_elem || load_err) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_elem) begin
         rsp_row_ff   <= i_ff;
         rsp_col_ff   <= j_ff;
         rsp_value_ff <= mac_result;
         rsp_last_ff  <= elem_last;
         rsp_err_ff   <= 1'b0;
      end else if (load_err) begin
         rsp_row_ff   <= '0;
         rsp_col_ff   <= '0;
         rsp_value_ff <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_err_ff   <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_size_error = rsp_err_ff;

   // ------------------------------------------------------------ assertions
   a_compute_holds_input: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == mm_pkg::OP_COMPUTE) |=> req_stall)
      else $error("compute transfer did not hold the request channel");

   a_error_result_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_size_error) |-> (rsp_last && rsp_out_value == '0))
      else $error("size error result not a single zero element");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_READ) |-> ({1'b0, k_ff} < cols_a_ff))
      else $error("term index beyond cols_a");

   a_elem_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_READ || state_ff == mm_pkg::ST_DRAIN)
      |-> ({1'b0, i_ff} < rows_a_ff && {1'b0, j_ff} < cols_b_ff))
      else $error("element index beyond the product size");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      load_elem |-> $past(state_ff == mm_pkg::ST_DRAIN || state_ff == mm_pkg::ST_READ))
      else $error("element loaded without a completed accumulation");

endmodule

// ----- tb/sv/matrix_multiply_checker.sv -----
// Self-checking monitor for the matrix multiply block: tracks register writes and
// element loads, predicts each product element and compares every response transfer.
// Depends on mm_pkg for the operation codes, register indexes and store geometry.

module matrix_multiply_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [1:0]               csr_index,
   input  logic [mm_pkg::CSR_W-1:0] csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [2:0]               req_row_index,
   input  logic [2:0]               req_col_index,
   input  logic [31:0]              req_elem_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [2:0]               rsp_out_row,
   input  logic [2:0]               rsp_out_col,
   input  logic [31:0]              rsp_out_value,
   input  logic                     rsp_last,
   input  logic                     rsp_size_error,
   output int                       fail_count,
   output int                       pending_count,
   output int                       result_count
);

   localparam int SUM_W = 72;   // wide enough for eight full-scale Q32.32 terms
   localparam logic signed [SUM_W-1:0] SAT_HI = 72'sh7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SAT_LO = -72'sh8000_0000;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        last;
      logic        size_error;
   } product_elem_type;

   product_elem_type product_q[$];

   logic [31:0] mat_a [mm_pkg::DEPTH];
   logic [31:0] mat_b [mm_pkg::DEPTH];
   logic [mm_pkg::CSR_W-1:0] a_rows, a_cols, b_rows, b_cols;

   // registers hold 0..15; the block works with 1..MAX_DIM
   function automatic int used_dim(input logic [mm_pkg::CSR_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > mm_pkg::MAX_DIM) return mm_pkg::MAX_DIM;
      return int'(v);
   endfunction

   // exact dot product, floored to Q16.16 and saturated
   function automatic logic [31:0] product_entry(input int i, input int j, input int n);
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] ta;
      logic signed [SUM_W-1:0] tb;
      acc = '0;
      for (int k = 0; k < n; k++) begin
         ta  = $signed(mat_a[i * mm_pkg::MAX_DIM + k]);
         tb  = $signed(mat_b[k * mm_pkg::MAX_DIM + j]);
         acc = acc + ta * tb;
      end
      acc = acc >>> mm_pkg::FRAC_W;
      if (acc > SAT_HI) return 32'h7FFF_FFFF;
      if (acc < SAT_LO) return 32'h8000_0000;
      return acc[31:0];
   endfunction

   task automatic predict_item(input logic [1:0] op, input logic [2:0] r, input logic [2:0] c,
                               input logic [31:0] v);
      int ra, ca, rb, cb;
      product_elem_type e;
      ra = used_dim(a_rows);
      ca = used_dim(a_cols);
      rb = used_dim(b_rows);
      cb = used_dim(b_cols);
      case (op)
         mm_pkg::OP_WRITE_A: begin
            if (int'(r) < ra && int'(c) < ca) mat_a[int'(r) * mm_pkg::MAX_DIM + int'(c)] = v;
         end
         mm_pkg::OP_WRITE_B: begin
            if (int'(r) < rb && int'(c) < cb) mat_b[int'(r) * mm_pkg::MAX_DIM + int'(c)] = v;
         end
         mm_pkg::OP_COMPUTE: begin
            if (ca != rb) begin
               e = '{row: 3'd0, col: 3'd0, value: 32'd0, last: 1'b1, size_error: 1'b1};
               product_q.insert(product_q.size(), e);
            end else begin
               for (int i = 0; i < ra; i++) begin
                  for (int j = 0; j < cb; j++) begin
                     e.row        = 3'(i);
                     e.col        = 3'(j);
                     e.value      = product_entry(i, j, ca);
                     e.last       = (i == ra - 1 && j == cb - 1);
                     e.size_error = 1'b0;
                     product_q.insert(product_q.size(), e);
                  end
               end
            end
         end
         default: ;   // unused code: drop
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: result %0d %s mismatch: expected %h, actual %h",
                  $time, result_count, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      product_elem_type want;
      if (reset) begin
         foreach (mat_a[k]) begin
            mat_a[k] = '0;
            mat_b[k] = '0;
         end
         a_rows = 4'd1;
         a_cols = 4'd1;
         b_rows = 4'd1;
         b_cols = 4'd1;
         product_q.delete();
         fail_count   = 0;
         result_count = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               mm_pkg::CSR_ROWS_A: a_rows = csr_wdata;
               mm_pkg::CSR_COLS_A: a_cols = csr_wdata;
               mm_pkg::CSR_ROWS_B: b_rows = csr_wdata;
               mm_pkg::CSR_COLS_B: b_cols = csr_wdata;
               default: ;
            endcase
         end
         // retire the response first: it can never belong to a request of this edge
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (product_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual row %0d col %0d value %h",
                        $time, rsp_out_row, rsp_out_col, rsp_out_value);
               fail_count++;
            end else begin
               want = product_q.pop_front();
               check_field("out_row", 32'(want.row), 32'(rsp_out_row));
               check_field("out_col", 32'(want.col), 32'(rsp_out_col));
               check_field("out_value", want.value, rsp_out_value);
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("size_error", 32'(want.size_error), 32'(rsp_size_error));
            end
         end
         if (req_valid && !req_stall)
            predict_item(req_op, req_row_index, req_col_index, req_elem_value);
      end
      pending_count = product_q.size();
   end

endmodule

// ----- tb/sv/matrix_multiply_tb.sv -----
// Top of the matrix multiply testbench: clock, reset, register writes and request
// stimulus with random idling; instantiates matrix_multiply and matrix_multiply_checker.
// Depends on mm_pkg for the operation codes and register indexes.

module matrix_multiply_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;   // spare code, the block must drop it
   localparam int SETTLE_CYCLES = 8;          // quiet cycles after the last result
   localparam int DRAIN_LIMIT   = 50000;      // cycles to wait for outstanding results
   localparam int RUN_LIMIT     = 2_000_000;  // time units

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     csr_wen        = 1'b0;
   logic [1:0]               csr_index      = 2'd0;
   logic [mm_pkg::CSR_W-1:0] csr_wdata      = '0;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_op         = 2'd0;
   logic [2:0]               req_row_index  = 3'd0;
   logic [2:0]               req_col_index  = 3'd0;
   logic signed [31:0]       req_elem_value = 32'sd0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic [2:0]               rsp_out_row;
   logic [2:0]               rsp_out_col;
   logic signed [31:0]       rsp_out_value;
   logic                     rsp_last;
   logic                     rsp_size_error;

   // idling percentages, changed between the three pressure modes
   int send_idle_pct = 20;
   int rsp_stall_pct = 55;

   int items_sent = 0, products_requested = 0, settings_used = 0, drain_fail = 0;
   int fail_count, pending_count, result_count;

   matrix_multiply dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .rsp_size_error (rsp_size_error)
   );

   matrix_multiply_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .rsp_size_error (rsp_size_error),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .result_count   (result_count)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure: redraw the stall every cycle, one assignment per edge.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Hard stop in case the block hangs or loses a result.
   initial begin
      #(RUN_LIMIT);
      $display("%0t: run limit reached with %0d results outstanding", $time, pending_count);
      $display("TEST FAILED");
      $finish;
   end

   // Element values: mostly the corners of Q16.16 and small numbers with fractions,
   // so that both saturation and the floor of negative sums get exercised.
   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom;
         3:       return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
         4:       return (32'($urandom_range(0, 16)) << 16) - 32'h0008_0000;
         default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      endcase
   endfunction

   // Register encoding of an effective size: sometimes use the out-of-range
   // values that the block must clamp (0 reads as 1, 9..15 read as 8).
   function automatic logic [3:0] encode_dim(input int eff);
      if (eff == 1 && $urandom_range(0, 2) == 0) return 4'd0;
      if (eff == mm_pkg::MAX_DIM && $urandom_range(0, 1) == 0) return 4'($urandom_range(9, 15));
      return 4'(eff);
   endfunction

   // Mostly small matrices keep the run short; now and then go up to the full size.
   function automatic int pick_dim();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(1, mm_pkg::MAX_DIM);
   endfunction

   // Write all four size registers back to back; only call while the block is idle.
   task automatic write_dims(input logic [3:0] ra, input logic [3:0] ca,
                             input logic [3:0] rb, input logic [3:0] cb);
      csr_wen   <= 1'b1;
      csr_index <= mm_pkg::CSR_ROWS_A;
      csr_wdata <= ra;
      @(posedge clock);
      csr_index <= mm_pkg::CSR_COLS_A;
      csr_wdata <= ca;
      @(posedge clock);
      csr_index <= mm_pkg::CSR_ROWS_B;
      csr_wdata <= rb;
      @(posedge clock);
      csr_index <= mm_pkg::CSR_COLS_B;
      csr_wdata <= cb;
      @(posedge clock);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // One request transfer. Valid stays high into the next call unless a gap
   // is drawn, so it is never lowered and raised within the same edge.
   task automatic send_item(input logic [1:0] op, input logic [2:0] r, input logic [2:0] c,
                            input logic [31:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_row_index  <= r;
      req_col_index  <= c;
      req_elem_value <= v;
      // hold the payload until the block takes it
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (op == mm_pkg::OP_COMPUTE) products_requested++;
   endtask

   // Drop valid, wait for every predicted result, then let the block settle.
   task automatic wait_drained();
      int n;
      req_valid <= 1'b0;
      n = 0;
      @(posedge clock);
      while (pending_count != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pending_count != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_count);
         drain_fail++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A load that is mostly in range for the current sizes, with some noise:
   // writes anywhere in the 8x8 grid (dropped when outside) and the unused code.
   task automatic send_load(input int ra, input int ca, input int rb, input int cb);
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
         send_item(OP_UNUSED, 3'($urandom), 3'($urandom), $urandom);
      end else if (kind < 15) begin
         send_item($urandom_range(0, 1) ? mm_pkg::OP_WRITE_B : mm_pkg::OP_WRITE_A,
                   3'($urandom), 3'($urandom), rand_elem());
      end else if ($urandom_range(0, 1) == 0) begin
         send_item(mm_pkg::OP_WRITE_A, 3'($urandom_range(0, ra - 1)),
                   3'($urandom_range(0, ca - 1)), rand_elem());
      end else begin
         send_item(mm_pkg::OP_WRITE_B, 3'($urandom_range(0, rb - 1)),
                   3'($urandom_range(0, cb - 1)), rand_elem());
      end
   endtask

   // One size setting: a few rounds of loads each closed by a product request.
   // Inner sizes match most of the time so that real products dominate.
   task automatic run_phase();
      int ra, ca, rb, cb, rounds;
      ra = pick_dim();
      ca = pick_dim();
      cb = pick_dim();
      rb = ($urandom_range(0, 9) == 0) ? pick_dim() : ca;
      write_dims(encode_dim(ra), encode_dim(ca), encode_dim(rb), encode_dim(cb));
      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
         repeat ($urandom_range(2, 14)) send_load(ra, ca, rb, cb);
         send_item(mm_pkg::OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
      end
      wait_drained();
   endtask

   initial begin : stimulus
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, sizes 1x1 from reset: cleared stores give a zero product.
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      // positive saturation
      send_item(mm_pkg::OP_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(mm_pkg::OP_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(mm_pkg::OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      // negative saturation
      send_item(mm_pkg::OP_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      // tiny negative product: floor must give -1 LSB, not zero
      send_item(mm_pkg::OP_WRITE_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
      send_item(mm_pkg::OP_WRITE_B, 3'd0, 3'd0, 32'h0000_8000);
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      // writes outside the size and the unused code must leave the stores alone
      send_item(mm_pkg::OP_WRITE_A, 3'd1, 3'd0, 32'h1234_5678);
      send_item(mm_pkg::OP_WRITE_B, 3'd0, 3'd7, 32'h7FFF_FFFF);
      send_item(OP_UNUSED, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      wait_drained();

      // Clamped registers: 15 reads as 8 and 0 as 1, giving the full 64-element outer product.
      write_dims(4'd15, 4'd0, 4'd0, 4'd15);
      send_item(mm_pkg::OP_WRITE_A, 3'd7, 3'd0, 32'h0001_0000);
      send_item(mm_pkg::OP_WRITE_B, 3'd0, 3'd7, 32'h8000_0000);
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      wait_drained();

      // Inner sizes differ: a single flagged zero result.
      write_dims(4'd2, 4'd3, 4'd2, 4'd2);
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      wait_drained();

      // Largest size: elements left over from the smaller settings take part again.
      write_dims(4'd8, 4'd8, 4'd8, 4'd8);
      send_item(mm_pkg::OP_WRITE_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
      send_item(mm_pkg::OP_WRITE_B, 3'd7, 3'd7, 32'h7FFF_FFFF);
      send_item(mm_pkg::OP_WRITE_A, 3'd7, 3'd6, 32'h8000_0000);
      send_item(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'd0);
      wait_drained();

      // Random part in three pressure modes: slow receiver, slow sender, then none.
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 20;
               rsp_stall_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               rsp_stall_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         while (items_sent < 20 + 65 * (mode + 1)) run_phase();
      end

      $display("Covered %0d request transfers, %0d product requests over %0d size settings,",
               items_sent, products_requested, settings_used);
      $display("%0d result transfers checked under three idling mixes.", result_count);
      if (fail_count == 0 && drain_fail == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mm_pkg.sv
rtl/core/mm_mac.sv
rtl/core/matrix_multiply.sv
tb/sv/matrix_multiply_checker.sv
tb/sv/matrix_multiply_tb.sv
